// ===== sv/l2tk_pkg.sv =====
// Shared types and constants of the L2 distance top-k selector.
package l2tk_pkg;

  localparam int MAX_LENGTH_DEF = 128;
  localparam int MAX_KEEP_DEF   = 16;

  localparam int KIND_W      = 2;
  localparam int ELEM_W      = 16;
  localparam int ID_W        = 32;
  localparam int DIST_W      = 48;
  localparam int SQ_W        = 32;
  localparam int RANK_W      = 4;
  localparam int VLEN_W      = 8;
  localparam int KEEP_W      = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 8'd128;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;
  localparam logic [DIST_W-1:0] DIST_ONES  = {DIST_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_QUERY = 2'd0,
    KIND_CAND  = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VLEN  = 2'd0,
    CFG_KEEP  = 2'd1,
    CFG_SPARE = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_index_t;

  // one kept neighbour
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
  } slot_t;

  // finished candidate or flush heading for the kept list
  typedef struct packed {
    logic              ins;
    logic              flush;
    logic [DIST_W-1:0] sq_dist;
    logic [ID_W-1:0]   id;
  } item_t;

endpackage

// ===== sv/l2tk_ifs.sv =====
// Channel interfaces of the L2 distance top-k selector.
interface l2tk_in_if;
  logic                                valid;
  logic                                ready;
  logic [l2tk_pkg::KIND_W-1:0]         kind;
  logic signed [l2tk_pkg::ELEM_W-1:0]  element_value;
  logic [l2tk_pkg::ID_W-1:0]           candidate_id;

  modport source (output valid, kind, element_value, candidate_id, input ready);
  modport sink   (input valid, kind, element_value, candidate_id, output ready);
endinterface

interface l2tk_out_if;
  logic                          valid;
  logic                          ready;
  logic [l2tk_pkg::RANK_W-1:0]   rank;
  logic [l2tk_pkg::ID_W-1:0]     neighbour_id;
  logic [l2tk_pkg::DIST_W-1:0]   distance;
  logic                          slot_valid;
  logic                          last_result;

  modport source (output valid, rank, neighbour_id, distance, slot_valid, last_result,
                  input ready);
  modport sink   (input valid, rank, neighbour_id, distance, slot_valid, last_result,
                  output ready);
endinterface

interface l2tk_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [l2tk_pkg::CFG_INDEX_W-1:0]   index;
  logic [l2tk_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/l2tk_dist.sv =====
// Element position, query store, squared difference and distance accumulation.
module l2tk_dist #(
  parameter int MAX_LENGTH = l2tk_pkg::MAX_LENGTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  l2tk_in_if.sink                      in_ch,
  input  logic                         adv,
  input  logic [$clog2(MAX_LENGTH+1)-1:0] eff_len,
  output l2tk_pkg::item_t              item_r
);

  localparam int AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LEN_W = $clog2(MAX_LENGTH+1);
  localparam int EW    = l2tk_pkg::ELEM_W;
  localparam int DW    = l2tk_pkg::DIST_W;

  l2tk_pkg::kind_t kind;
  logic                  accept;
  logic [AW-1:0]         cnt_r, cnt_nxt, pos;
  logic [LEN_W-1:0]      pos_inc;
  logic                  at_end;

  logic signed [EW-1:0]  qmem [MAX_LENGTH];
  logic signed [EW-1:0]  q_rd_r;

  logic                  s1_cand_r, s1_flush_r, s1_first_r, s1_last_r;
  logic signed [EW-1:0]  s1_elem_r;
  logic [l2tk_pkg::ID_W-1:0] s1_id_r;

  logic signed [EW:0]    diff;
  logic [EW-1:0]         mag;

  logic                  s2_cand_r, s2_flush_r, s2_first_r, s2_last_r;
  logic [l2tk_pkg::ID_W-1:0] s2_id_r;
  logic [l2tk_pkg::SQ_W-1:0] s2_sq_r;

  logic [DW-1:0]         acc_r, sat;
  logic [DW:0]           sum;
  logic [l2tk_pkg::ID_W-1:0] cur_id_r;

  assign kind        = l2tk_pkg::kind_t'(in_ch.kind);
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  // a counter left past a shortened length restarts at zero
  assign pos     = (LEN_W'(cnt_r) >= eff_len) ? '0 : cnt_r;
  assign pos_inc = LEN_W'(pos) + LEN_W'(1);
  assign at_end  = pos_inc >= eff_len;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      case (kind)
        l2tk_pkg::KIND_QUERY, l2tk_pkg::KIND_CAND: cnt_nxt = at_end ? '0 : AW'(pos_inc);
        l2tk_pkg::KIND_FLUSH:                      cnt_nxt = '0;
        default:                                   cnt_nxt = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind == l2tk_pkg::KIND_QUERY) begin
      qmem[pos] <= in_ch.element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_rd_r <= qmem[pos];
    end
  end

  // stage 1: element with its query value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_cand_r  <= 1'b0;
      s1_flush_r <= 1'b0;
    end else if (adv) begin
      s1_cand_r  <= accept && kind == l2tk_pkg::KIND_CAND;
      s1_flush_r <= accept && kind == l2tk_pkg::KIND_FLUSH;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first_r <= pos == '0;
      s1_last_r  <= at_end;
      s1_elem_r  <= in_ch.element_value;
      s1_id_r    <= in_ch.candidate_id;
    end
  end

  assign diff = {s1_elem_r[EW-1], s1_elem_r} - {q_rd_r[EW-1], q_rd_r};
  assign mag  = diff[EW] ? EW'(-diff) : EW'(diff);

  // stage 2: squared difference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_cand_r  <= 1'b0;
      s2_flush_r <= 1'b0;
    end else if (adv) begin
      s2_cand_r  <= s1_cand_r;
      s2_flush_r <= s1_flush_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_id_r    <= s1_id_r;
      s2_sq_r    <= l2tk_pkg::SQ_W'(mag) * l2tk_pkg::SQ_W'(mag);
    end
  end

  assign sum = (s2_first_r ? {(DW+1){1'b0}} : (DW+1)'(acc_r)) + (DW+1)'(s2_sq_r);
  assign sat = sum[DW] ? l2tk_pkg::DIST_ONES : sum[DW-1:0];

  // stage 3: accumulate; a finished candidate or a flush goes on to the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cur_id_r <= '0;
      item_r   <= '0;
    end else if (adv) begin
      if (s2_cand_r) begin
        acc_r <= s2_last_r ? '0 : sat;
        if (s2_first_r) begin
          cur_id_r <= s2_id_r;
        end
      end else if (s2_flush_r) begin
        acc_r <= '0;
      end
      item_r.ins     <= s2_cand_r && s2_last_r;
      item_r.flush   <= s2_flush_r;
      item_r.sq_dist <= sat;
      item_r.id      <= s2_first_r ? s2_id_r : cur_id_r;
    end
  end

endmodule

// ===== sv/l2tk_list.sv =====
// Sorted list of kept neighbours with parallel compare and insert.
module l2tk_list #(
  parameter int MAX_KEEP = l2tk_pkg::MAX_KEEP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  l2tk_pkg::item_t               item,
  input  logic [$clog2(MAX_KEEP+1)-1:0] eff_keep,
  output logic                          load,
  output l2tk_pkg::slot_t               slots [MAX_KEEP]
);

  localparam int KW = $clog2(MAX_KEEP+1);

  l2tk_pkg::slot_t slot_r   [MAX_KEEP];
  l2tk_pkg::slot_t slot_nxt [MAX_KEEP];
  l2tk_pkg::slot_t prev     [MAX_KEEP];
  l2tk_pkg::slot_t fresh;
  logic [MAX_KEEP-1:0] in_rng, hit, past_hit;

  assign fresh = '{valid: 1'b1, id: item.id, sq_dist: item.sq_dist};
  assign load  = adv && item.flush;

  always_comb begin
    prev[0]     = slot_r[0];
    past_hit[0] = 1'b0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      in_rng[i] = KW'(i) < eff_keep;
      hit[i]    = in_rng[i] && (!slot_r[i].valid || item.sq_dist < slot_r[i].sq_dist);
    end
    for (int i = 1; i < MAX_KEEP; i++) begin
      prev[i]     = slot_r[i-1];
      past_hit[i] = past_hit[i-1] | hit[i-1];
    end
    for (int i = 0; i < MAX_KEEP; i++) begin
      slot_nxt[i] = slot_r[i];
      if (adv && item.ins && in_rng[i]) begin
        if (past_hit[i]) begin
          slot_nxt[i] = prev[i];
        end else if (hit[i]) begin
          slot_nxt[i] = fresh;
        end
      end
      if (load) begin
        slot_nxt[i].valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      slot_r[i].id      <= slot_nxt[i].id;
      slot_r[i].sq_dist <= slot_nxt[i].sq_dist;
    end
    if (!rst_n) begin
      for (int i = 0; i < MAX_KEEP; i++) begin
        slot_r[i].valid <= 1'b0;
      end
    end else begin
      for (int i = 0; i < MAX_KEEP; i++) begin
        slot_r[i].valid <= slot_nxt[i].valid;
      end
    end
  end

  assign slots = slot_r;

endmodule

// ===== sv/l2tk_emit.sv =====
// Result shift register that drains a snapshot of the kept list best-first.
module l2tk_emit #(
  parameter int MAX_KEEP = l2tk_pkg::MAX_KEEP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  l2tk_pkg::slot_t               slots [MAX_KEEP],
  input  logic [$clog2(MAX_KEEP+1)-1:0] eff_keep,
  l2tk_out_if.source                    out_ch,
  output logic                          busy
);

  localparam int KW = $clog2(MAX_KEEP+1);

  l2tk_pkg::slot_t em_r [MAX_KEEP];
  logic [KW-1:0]   cnt_r;
  logic [l2tk_pkg::RANK_W-1:0] rank_r;
  logic            take;

  assign busy = cnt_r != '0;
  assign take = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (load) begin
      em_r <= slots;
    end else if (take) begin
      for (int i = 0; i < MAX_KEEP - 1; i++) begin
        em_r[i] <= em_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rank_r <= '0;
    end else if (load) begin
      cnt_r  <= eff_keep;
      rank_r <= '0;
    end else if (take) begin
      cnt_r  <= cnt_r - KW'(1);
      rank_r <= rank_r + l2tk_pkg::RANK_W'(1);
    end
  end

  assign out_ch.valid        = busy;
  assign out_ch.rank         = rank_r;
  assign out_ch.slot_valid   = em_r[0].valid;
  assign out_ch.neighbour_id = em_r[0].valid ? em_r[0].id : '0;
  assign out_ch.distance     = em_r[0].valid ? em_r[0].sq_dist : l2tk_pkg::DIST_ONES;
  assign out_ch.last_result  = cnt_r == KW'(1);

endmodule

// ===== sv/l2_distance_topk_selector_core.sv =====
// Top level of the exact squared-L2 top-k nearest neighbour selector.
//
// in_ch carries items: a query element (stored at the current position), a
// candidate element (id taken with its first element), or a flush. Query and
// candidate elements share one position counter that wraps after
// vector_length elements. A finished candidate enters the sorted list if a
// slot in range is empty or it is strictly closer than the worst kept entry;
// ties stay in arrival order. A flush produces keep_count items on out_ch,
// rank 0 first, empty slots marked invalid, and clears the list.
// cfg_ch writes vector_length (index 0) and keep_count (index 1); it is
// always ready; the user must use it only while idle (the block does not check).
// Throughput: one input item per cycle, held while a flush waits on the drain,
// through a four-stage pipeline (query store read, square, accumulate, list
// insert). A flush passes stages 1, 2 and 3 and then loads the result shift
// register, which gives one result per cycle while out_ch.ready is high. A
// second flush reaching the list while results are still draining holds
// in_ch.ready low until the last result is taken; candidates and query elements
// keep flowing otherwise. A stalled receiver holds the current result steady.
// Reset (rst_n low, synchronous) empties the list, zeroes the counter and
// accumulator and restores the register defaults; no clearing pass.
module l2_distance_topk_selector_core #(
  parameter int MAX_LENGTH = l2tk_pkg::MAX_LENGTH_DEF,
  parameter int MAX_KEEP   = l2tk_pkg::MAX_KEEP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  l2tk_in_if.sink     in_ch,
  l2tk_out_if.source  out_ch,
  l2tk_cfg_if.sink    cfg_ch
);

  localparam int LEN_W = $clog2(MAX_LENGTH+1);
  localparam int KW    = $clog2(MAX_KEEP+1);

  logic [l2tk_pkg::VLEN_W-1:0] vlen_r;
  logic [l2tk_pkg::KEEP_W-1:0] keep_r;
  logic [LEN_W-1:0]            eff_len;
  logic [KW-1:0]               eff_keep;
  logic                        adv, load, busy;
  l2tk_pkg::item_t             item;
  l2tk_pkg::slot_t             slots [MAX_KEEP];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= l2tk_pkg::VLEN_RESET;
      keep_r <= l2tk_pkg::KEEP_RESET;
    end else if (cfg_ch.valid) begin
      case (l2tk_pkg::cfg_index_t'(cfg_ch.index))
        l2tk_pkg::CFG_VLEN: vlen_r <= cfg_ch.data;
        l2tk_pkg::CFG_KEEP: keep_r <= cfg_ch.data[l2tk_pkg::KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, values above the build limits clamp
  always_comb begin
    if (vlen_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(vlen_r) > 32'(MAX_LENGTH)) begin
      eff_len = LEN_W'(MAX_LENGTH);
    end else begin
      eff_len = LEN_W'(vlen_r);
    end
    if (keep_r == '0) begin
      eff_keep = KW'(1);
    end else if (32'(keep_r) > 32'(MAX_KEEP)) begin
      eff_keep = KW'(MAX_KEEP);
    end else begin
      eff_keep = KW'(keep_r);
    end
  end

  // the whole pipeline holds while a flush waits for the result drain
  assign adv = !(item.flush && busy);

  l2tk_dist #(.MAX_LENGTH(MAX_LENGTH)) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .adv     (adv),
    .eff_len (eff_len),
    .item_r  (item)
  );

  l2tk_list #(.MAX_KEEP(MAX_KEEP)) u_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .item     (item),
    .eff_keep (eff_keep),
    .load     (load),
    .slots    (slots)
  );

  l2tk_emit #(.MAX_KEEP(MAX_KEEP)) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .slots    (slots),
    .eff_keep (eff_keep),
    .out_ch   (out_ch),
    .busy     (busy)
  );

endmodule

// ===== sv/l2tk_checker.sv =====
// Port-level checks of the selector, bound to the top level.
module l2tk_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [l2tk_pkg::RANK_W-1:0]     rank,
  input logic [l2tk_pkg::ID_W-1:0]       neighbour_id,
  input logic [l2tk_pkg::DIST_W-1:0]     distance,
  input logic                            slot_valid,
  input logic                            last_result
);

  // a waiting result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rank) && $stable(distance)
      && $stable(neighbour_id) && $stable(last_result))
    else $error("result changed while stalled");

  // results of one flush follow back to back with rising rank
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_result |=>
      out_valid && rank == $past(rank) + l2tk_pkg::RANK_W'(1))
    else $error("flush results not consecutive");

  // an empty slot shows the fixed empty pattern
  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !slot_valid |-> neighbour_id == '0 && distance == l2tk_pkg::DIST_ONES)
    else $error("empty slot carries data");

  // input only stalls behind a result drain
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind l2_distance_topk_selector_core l2tk_checker u_l2tk_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .rank         (out_ch.rank),
  .neighbour_id (out_ch.neighbour_id),
  .distance     (out_ch.distance),
  .slot_valid   (out_ch.slot_valid),
  .last_result  (out_ch.last_result)
);

// ===== sim/l2tk_topk_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the top-k selector: mirrors its state and checks every result item.
module l2tk_topk_checker (
  input  logic clk,
  input  logic rst_n,
  l2tk_in_if   in_mon,
  l2tk_out_if  out_mon,
  l2tk_cfg_if  cfg_mon,
  output int   mismatch_count,
  output int   pending_count,
  output int   results_checked,
  output int   candidates_finished
);
  import l2tk_pkg::*;

  localparam int QDEPTH    = MAX_LENGTH_DEF;
  localparam int KDEPTH    = MAX_KEEP_DEF;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   nbr_id;
    logic [DIST_W-1:0] sq_dist;
    logic              occupied;
    logic              last;
  } nbr_result_t;

  logic [VLEN_W-1:0]        vlen_reg;
  logic [KEEP_W-1:0]        keep_reg;
  logic signed [ELEM_W-1:0] query_mem [QDEPTH];
  int unsigned              elem_pos;
  logic [DIST_W-1:0]        dist_acc;
  logic [ID_W-1:0]          cand_id;
  logic [DIST_W-1:0]        kept_dist [KDEPTH];
  logic [ID_W-1:0]          kept_id   [KDEPTH];
  logic                     kept_used [KDEPTH];
  nbr_result_t              expected_results [$];
  int                       fail_tally     = 0;
  int                       checked_tally  = 0;
  int                       finished_tally = 0;

  function automatic int unsigned active_length();
    if (vlen_reg == '0) return 1;
    if (vlen_reg > QDEPTH) return QDEPTH;
    return vlen_reg;
  endfunction

  function automatic int active_keep();
    if (keep_reg == '0) return 1;
    if (keep_reg > KDEPTH) return KDEPTH;
    return keep_reg;
  endfunction

  task automatic report_mismatch(input string msg);
    // keep the log bounded when the block is badly broken
    if (fail_tally < PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, msg);
    fail_tally++;
  endtask

  task automatic clear_list();
    for (int i = 0; i < KDEPTH; i++) begin
      kept_dist[i] = DIST_ONES;
      kept_id[i]   = '0;
      kept_used[i] = 1'b0;
    end
  endtask

  task automatic apply_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_VLEN: vlen_reg = data[VLEN_W-1:0];
      CFG_KEEP: keep_reg = data[KEEP_W-1:0];
      default: ;
    endcase
  endtask

  // empty slot always takes it; a kept one only yields to a strictly smaller distance
  task automatic rank_candidate(input logic [DIST_W-1:0] d, input logic [ID_W-1:0] id);
    int k;
    int slot;
    k    = active_keep();
    slot = k;
    for (int i = 0; i < k; i++)
      if (slot == k && (!kept_used[i] || d < kept_dist[i])) slot = i;
    if (slot < k) begin
      for (int i = k - 1; i > slot; i--) begin
        kept_dist[i] = kept_dist[i-1];
        kept_id[i]   = kept_id[i-1];
        kept_used[i] = kept_used[i-1];
      end
      kept_dist[slot] = d;
      kept_id[slot]   = id;
      kept_used[slot] = 1'b1;
    end
  endtask

  task automatic apply_item(input kind_t kind_in, input logic signed [ELEM_W-1:0] value,
                            input logic [ID_W-1:0] id);
    int unsigned len;
    int unsigned p;
    int          k;
    longint      diff;
    logic [63:0] sum;
    nbr_result_t r;
    len = active_length();
    p   = (elem_pos >= len) ? 0 : elem_pos;
    case (kind_in)
      KIND_QUERY: begin
        query_mem[p] = value;
        elem_pos = (p + 1 >= len) ? 0 : p + 1;
      end
      KIND_CAND: begin
        if (p == 0) begin
          cand_id  = id;
          dist_acc = '0;
        end
        diff     = longint'(value) - longint'(query_mem[p]);
        sum      = 64'(dist_acc) + 64'(diff * diff);
        dist_acc = (sum > 64'(DIST_ONES)) ? DIST_ONES : sum[DIST_W-1:0];
        if (p + 1 >= len) begin
          rank_candidate(dist_acc, cand_id);
          finished_tally++;
          elem_pos = 0;
          dist_acc = '0;
        end else begin
          elem_pos = p + 1;
        end
      end
      KIND_FLUSH: begin
        k = active_keep();
        for (int i = 0; i < k; i++) begin
          r.rank     = RANK_W'(i);
          r.nbr_id   = kept_used[i] ? kept_id[i] : ID_W'(0);
          r.sq_dist  = kept_used[i] ? kept_dist[i] : DIST_ONES;
          r.occupied = kept_used[i];
          r.last     = (i == k - 1);
          expected_results.push_back(r);
        end
        clear_list();
        elem_pos = 0;
        dist_acc = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    nbr_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: rank %0d id %h dist %h",
                                out_mon.rank, out_mon.neighbour_id, out_mon.distance));
      return;
    end
    want = expected_results.pop_front();
    checked_tally++;
    if (out_mon.rank !== want.rank)
      report_mismatch($sformatf("rank: got %0d want %0d", out_mon.rank, want.rank));
    if (out_mon.neighbour_id !== want.nbr_id)
      report_mismatch($sformatf("rank %0d neighbour_id: got %h want %h",
                                want.rank, out_mon.neighbour_id, want.nbr_id));
    if (out_mon.distance !== want.sq_dist)
      report_mismatch($sformatf("rank %0d distance: got %h want %h",
                                want.rank, out_mon.distance, want.sq_dist));
    if (out_mon.slot_valid !== want.occupied)
      report_mismatch($sformatf("rank %0d slot_valid: got %b want %b",
                                want.rank, out_mon.slot_valid, want.occupied));
    if (out_mon.last_result !== want.last)
      report_mismatch($sformatf("rank %0d last_result: got %b want %b",
                                want.rank, out_mon.last_result, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      vlen_reg = VLEN_RESET;
      keep_reg = KEEP_RESET;
      elem_pos = 0;
      dist_acc = '0;
      cand_id  = '0;
      clear_list();
      expected_results.delete();
    end else begin
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1)
        apply_register(cfg_index_t'(cfg_mon.index), cfg_mon.data);
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
        check_result();
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        apply_item(kind_t'(in_mon.kind), in_mon.element_value, in_mon.candidate_id);
    end
    mismatch_count      <= fail_tally;
    pending_count       <= expected_results.size();
    results_checked     <= checked_tally;
    candidates_finished <= finished_tally;
  end

endmodule

// ===== sim/tb_l2_distance_topk_selector_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the top-k selector: clock, reset, stimulus and verdict.
module tb_l2_distance_topk_selector_core;
  import l2tk_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 10;
  localparam int GROUP_ITEMS   = 20;
  localparam int LIMIT_NS      = 2_000_000;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;

  typedef enum int {VAL_RANDOM, VAL_EXTREME, VAL_SMALL} query_style_t;
  typedef enum int {CAND_RANDOM, CAND_NEAR, CAND_EXACT, CAND_REPEAT, CAND_FAR} cand_mode_t;

  logic clk;
  logic rst_n;
  logic send_gaps    = 1'b0;
  logic recv_stalls  = 1'b0;
  logic hold_request = 1'b0;
  int   items_sent   = 0;
  int   reg_writes   = 0;
  int   mismatches;
  int   pending;
  int   results_checked;
  int   cands_finished;

  logic signed [ELEM_W-1:0] query_copy [MAX_LENGTH_DEF];
  logic signed [ELEM_W-1:0] prev_cand  [MAX_LENGTH_DEF];

  l2tk_in_if  in_ch ();
  l2tk_out_if out_ch ();
  l2tk_cfg_if cfg_ch ();

  l2_distance_topk_selector_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  l2tk_topk_checker topk_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mon              (in_ch),
    .out_mon             (out_ch),
    .cfg_mon             (cfg_ch),
    .mismatch_count      (mismatches),
    .pending_count       (pending),
    .results_checked     (results_checked),
    .candidates_finished (cands_finished)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_l2_distance_topk_selector_core failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    logic hold_done;
    hold_done    = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    return ELEM_W'($urandom);
  endfunction

  // valid is left high after acceptance so back-to-back items need no bubble
  task automatic send_item(input kind_t k, input logic signed [ELEM_W-1:0] v,
                           input logic [ID_W-1:0] id);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= k;
    in_ch.element_value <= v;
    in_ch.candidate_id  <= id;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (k != KIND_NONE) items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // candidates still in the pipe produce nothing, so give them time
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic load_query(input int len, input query_style_t style);
    logic signed [ELEM_W-1:0] v;
    for (int i = 0; i < len; i++) begin
      case (style)
        VAL_EXTREME: v = i[0] ? ELEM_MIN : ELEM_MAX;
        VAL_SMALL:   v = ELEM_W'(int'($urandom_range(0, 64)) - 32);
        default:     v = rand_elem();
      endcase
      query_copy[i] = v;
      send_item(KIND_QUERY, v, $urandom);
    end
  endtask

  // n_elems below len leaves the candidate unfinished
  task automatic send_candidate(input int len, input int n_elems, input cand_mode_t mode);
    logic [ID_W-1:0]          id;
    logic signed [ELEM_W-1:0] v;
    id = $urandom;
    for (int i = 0; i < n_elems; i++) begin
      case (mode)
        CAND_NEAR:   v = query_copy[i] + ELEM_W'(int'($urandom_range(0, 6)) - 3);
        CAND_EXACT:  v = query_copy[i];
        CAND_REPEAT: v = prev_cand[i];
        CAND_FAR:    v = (query_copy[i] < 0) ? ELEM_MAX : ELEM_MIN;
        default:     v = rand_elem();
      endcase
      prev_cand[i] = v;
      send_item(KIND_CAND, v, (i == 0) ? id : ID_W'($urandom));
    end
  endtask

  task automatic run_group(input int len, input int keep);
    int n;
    send_gaps   = ($urandom_range(0, 3) != 0);
    recv_stalls = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 1) == 0) load_query(len, query_style_t'($urandom_range(0, 2)));
    n = $urandom_range(1, keep + 3);
    // long vectors get fewer candidates so the run stays short
    if (n * len > GROUP_ITEMS) n = (GROUP_ITEMS + len - 1) / len;
    for (int c = 0; c < n; c++) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) send_item(KIND_NONE, rand_elem(), $urandom);
        else send_item(KIND_QUERY, rand_elem(), $urandom);
      end
      send_candidate(len, len, cand_mode_t'($urandom_range(0, 4)));
    end
    if (len > 1 && $urandom_range(0, 4) == 0)
      send_candidate(len, $urandom_range(1, len - 1), CAND_RANDOM);
    send_item(KIND_FLUSH, rand_elem(), $urandom);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] len_w;
    logic [CFG_DATA_W-1:0] keep_w;
    int                    len_eff;
    int                    keep_eff;
    int                    phase_start;

    for (int i = 0; i < MAX_LENGTH_DEF; i++) begin
      query_copy[i] = '0;
      prev_cand[i]  = '0;
    end
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_NONE;
    in_ch.element_value <= '0;
    in_ch.candidate_id  <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_VLEN;
    cfg_ch.data         <= '0;
    rst_n               <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: fill the positions used later, then flush partial work
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    load_query(8, VAL_EXTREME);
    send_item(KIND_FLUSH, '0, '0);
    send_candidate(MAX_LENGTH_DEF, 5, CAND_NEAR);
    send_item(KIND_FLUSH, ELEM_MIN, 32'hFFFF_FFFF);

    // directed: two-element vectors, three kept
    write_reg(CFG_VLEN, 8'd2);
    write_reg(CFG_KEEP, 8'd3);
    write_reg(CFG_SPARE, 8'hFF);
    write_reg(CFG_UNUSED, 8'hAA);
    send_item(KIND_QUERY, ELEM_MAX, '0);
    send_item(KIND_QUERY, ELEM_MIN, '0);
    send_item(KIND_CAND, ELEM_MIN, 32'hFFFF_FFFF);
    send_item(KIND_CAND, ELEM_MAX, '0);
    send_item(KIND_CAND, ELEM_MAX, 32'd0);
    send_item(KIND_CAND, ELEM_MIN, 32'hFFFF_FFFF);
    send_item(KIND_NONE, ELEM_MIN, 32'hFFFF_FFFF);
    send_item(KIND_CAND, ELEM_MAX, 32'd1234);
    send_item(KIND_CAND, 16'sd0, '0);
    // equal distance: kept after the older one
    send_item(KIND_CAND, ELEM_MAX, 32'hA5A5_A5A5);
    send_item(KIND_CAND, 16'sd0, '0);
    // equal to the worst kept: not taken
    send_item(KIND_CAND, ELEM_MAX, 32'd77);
    send_item(KIND_CAND, 16'sd0, '0);
    send_item(KIND_CAND, ELEM_MAX, 32'h5A5A_5A5A);
    send_item(KIND_CAND, 16'sh8001, '0);
    // query element lands in the middle of a candidate
    send_item(KIND_CAND, 16'sd0, 32'd99);
    send_item(KIND_QUERY, 16'sd100, '0);
    send_item(KIND_CAND, ELEM_MAX, 32'd42);
    send_item(KIND_CAND, 16'sd100, '0);
    // partial candidate dropped by the flush
    send_item(KIND_CAND, 16'sd5, 32'd7);
    send_item(KIND_FLUSH, '0, '0);
    send_item(KIND_FLUSH, '0, '0);
    // zero in both registers acts as one
    write_reg(CFG_VLEN, 8'h00);
    write_reg(CFG_KEEP, 8'hE0);
    send_item(KIND_QUERY, -16'sd1, '0);
    send_item(KIND_CAND, 16'sd1, 32'd3);
    send_item(KIND_FLUSH, '0, '0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin len_w = 8'd1; keep_w = 8'hFF; keep_eff = MAX_KEEP_DEF; end
        1: begin len_w = 8'd3; keep_w = 8'd1;  keep_eff = 1; end
        2: begin
          len_w    = 8'($urandom_range(2, 6));
          keep_eff = $urandom_range(1, MAX_KEEP_DEF);
          keep_w   = 8'(keep_eff);
        end
        3: begin
          len_w    = 8'($urandom_range(1, 8));
          keep_eff = $urandom_range(1, MAX_KEEP_DEF);
          keep_w   = 8'(keep_eff);
        end
        default: begin len_w = 8'd4; keep_w = 8'd16; keep_eff = MAX_KEEP_DEF; end
      endcase
      len_eff = len_w;
      write_reg(CFG_VLEN, len_w);
      write_reg(CFG_KEEP, keep_w);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_group(len_eff, keep_eff);
    end

    // long hold on the result side while items keep coming: a second flush must stall
    write_reg(CFG_VLEN, 8'd2);
    write_reg(CFG_KEEP, 8'd16);
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    load_query(2, VAL_SMALL);
    repeat (4) send_candidate(2, 2, CAND_RANDOM);
    hold_request = 1'b1;
    send_item(KIND_FLUSH, '0, '0);
    repeat (3) send_candidate(2, 2, CAND_NEAR);
    send_item(KIND_FLUSH, '0, '0);
    repeat (2) send_candidate(2, 2, CAND_REPEAT);
    send_item(KIND_FLUSH, '0, '0);

    // closing part without idling
    write_reg(CFG_VLEN, 8'd4);
    write_reg(CFG_KEEP, 8'd16);
    load_query(4, VAL_RANDOM);
    send_candidate(4, 4, CAND_RANDOM);
    send_candidate(4, 4, CAND_NEAR);
    send_candidate(4, 4, CAND_EXACT);
    send_item(KIND_FLUSH, '0, '0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d items and %0d register writes, lengths 1 to 8, keep 1 to 16.",
             items_sent, reg_writes);
    $display("%0d candidates ranked, %0d neighbour results compared.",
             cands_finished, results_checked);
    if (mismatches == 0) begin
      $display("tb_l2_distance_topk_selector_core passed");
    end else begin
      $display("tb_l2_distance_topk_selector_core failed");
    end
    $finish;
  end

endmodule
